FILE: hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS = 30;
	localparam int IN_W      = 32;
	localparam int OUT_W     = 32;
	localparam int SUM_W     = 35;
	localparam int MAG_W     = 31;
	localparam int POS_W     = 6;
	localparam int N_W       = 64;
	localparam int R_W       = 32;
	localparam int REM_W     = R_W + 1;
	localparam int Q_W       = FRAC_BITS + 2;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic signed [IN_W-1:0] north_x;
		logic signed [IN_W-1:0] north_y;
		logic signed [IN_W-1:0] north_z;
		logic signed [IN_W-1:0] east_x;
		logic signed [IN_W-1:0] east_y;
		logic signed [IN_W-1:0] east_z;
		logic signed [IN_W-1:0] down_x;
		logic signed [IN_W-1:0] down_y;
		logic signed [IN_W-1:0] down_z;
	} rmq_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] quat_w;
		logic signed [OUT_W-1:0] quat_i;
		logic signed [OUT_W-1:0] quat_j;
		logic signed [OUT_W-1:0] quat_k;
		logic                    degenerate;
	} rmq_out_t;

	// Normalized magnitudes with their signs, as passed from front to back.
	typedef struct packed {
		logic [3:0][MAG_W-1:0] mag;
		logic [3:0]            neg;
		logic                  dgn;
	} rmq_norm_t;

endpackage

FILE: hdl/rmq_queue.sv
// ----------------------------------------------------------------------------
// rmq_queue
// Short first-in first-out queue of normalized words between front and back.
// ----------------------------------------------------------------------------
module rmq_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  rmq_pkg::rmq_norm_t wdata,
	output logic              full,
	input  logic              rd,
	output rmq_pkg::rmq_norm_t rdata,
	output logic              empty
);

	rmq_pkg::rmq_norm_t               mem_q [rmq_pkg::QUEUE_DEPTH];
	logic [rmq_pkg::QUEUE_AW-1:0]     wp_q;
	logic [rmq_pkg::QUEUE_AW-1:0]     rp_q;
	logic [rmq_pkg::QUEUE_AW:0]       cnt_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full  = cnt_q == (rmq_pkg::QUEUE_AW+1)'(rmq_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (rmq_pkg::QUEUE_AW+1)'(rmq_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

FILE: hdl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Forms four candidate sums, picks the largest, builds the scaled quaternion
// vector and normalizes its magnitudes so the largest is in [2^30, 2^31).
// ----------------------------------------------------------------------------
module rmq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rmq_pkg::rmq_in_t   matrix,
	output logic               full,
	output logic               q_wr,
	output rmq_pkg::rmq_norm_t q_data,
	input  logic               q_full
);

	localparam int SW = rmq_pkg::SUM_W;
	localparam logic signed [SW-1:0] ONE = SW'(1) <<< rmq_pkg::FRAC_BITS;

	logic adv;

	// Stage 1: candidate sums and selection.
	logic                 v_s1;
	logic signed [SW-1:0] s_s1;
	logic [1:0]           sel_s1;
	logic signed [SW-1:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1;

	logic signed [SW-1:0] nx, ny, nz, ex, ey, ez, dx, dy, dz;
	logic signed [SW-1:0] c0, c1, c2, c3, best;
	logic [1:0]           bsel;

	// Stage 2: vector magnitudes and their maximum.
	logic                 v_s2;
	logic [3:0][SW-1:0]   mag_s2;
	logic [3:0]           neg_s2;
	logic [SW-1:0]        max_s2;
	logic                 dgn_s2;

	logic signed [3:0][SW-1:0] vv;
	logic [3:0][SW-1:0]        vm;
	logic [3:0]                vn;
	logic [SW-1:0]             m01, m23;

	// Stage 3: normalized word.
	logic                 v_s3;
	rmq_pkg::rmq_norm_t   nrm_s3;

	logic [rmq_pkg::POS_W-1:0] pos;
	rmq_pkg::rmq_norm_t        nrm;

	assign adv  = ~(v_s3 & q_full);
	assign full = ~adv;
	assign q_wr = v_s3 & ~q_full;
	assign q_data = nrm_s3;

	always_comb begin
		nx = SW'(matrix.north_x);
		ny = SW'(matrix.north_y);
		nz = SW'(matrix.north_z);
		ex = SW'(matrix.east_x);
		ey = SW'(matrix.east_y);
		ez = SW'(matrix.east_z);
		dx = SW'(matrix.down_x);
		dy = SW'(matrix.down_y);
		dz = SW'(matrix.down_z);
		c0 = ONE + nx + ey + dz;
		c1 = ONE + nx - ey - dz;
		c2 = ONE - nx + ey - dz;
		c3 = ONE - nx - ey + dz;
		// A later candidate wins only when strictly larger.
		best = c0;
		bsel = 2'd0;
		if (c1 > best) begin
			best = c1;
			bsel = 2'd1;
		end
		if (c2 > best) begin
			best = c2;
			bsel = 2'd2;
		end
		if (c3 > best) begin
			best = c3;
			bsel = 2'd3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1   <= best;
			sel_s1 <= bsel;
			a_s1   <= dy - ez;
			b_s1   <= nz - dx;
			c_s1   <= ex - ny;
			d_s1   <= ny + ex;
			e_s1   <= nz + dx;
			f_s1   <= ez + dy;
		end
	end

	always_comb begin
		unique case (sel_s1)
			2'd0: vv = {c_s1, b_s1, a_s1, s_s1};
			2'd1: vv = {e_s1, d_s1, s_s1, a_s1};
			2'd2: vv = {f_s1, s_s1, d_s1, b_s1};
			default: vv = {s_s1, f_s1, e_s1, c_s1};
		endcase
		for (int k = 0; k < 4; k++) begin
			vn[k] = vv[k][SW-1];
			vm[k] = vn[k] ? SW'(-vv[k]) : vv[k];
		end
		m01 = (vm[1] > vm[0]) ? vm[1] : vm[0];
		m23 = (vm[3] > vm[2]) ? vm[3] : vm[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2 <= vm;
			neg_s2 <= vn;
			max_s2 <= (m23 > m01) ? m23 : m01;
			dgn_s2 <= (s_s1 <= 0);
		end
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < SW; i++) begin
			if (max_s2[i]) begin
				pos = rmq_pkg::POS_W'(i);
			end
		end
		nrm.neg = neg_s2;
		nrm.dgn = dgn_s2;
		// The largest magnitude lands in [2^30, 2^31); a right shift truncates.
		for (int k = 0; k < 4; k++) begin
			if (dgn_s2) begin
				nrm.mag[k] = '0;
			end else if (pos > rmq_pkg::POS_W'(rmq_pkg::MAG_W - 1)) begin
				nrm.mag[k] = rmq_pkg::MAG_W'(mag_s2[k] >>
					(pos - rmq_pkg::POS_W'(rmq_pkg::MAG_W - 1)));
			end else begin
				nrm.mag[k] = rmq_pkg::MAG_W'(mag_s2[k] <<
					(rmq_pkg::POS_W'(rmq_pkg::MAG_W - 1) - pos));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_s3 <= nrm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !nrm_s3.dgn |->
		(nrm_s3.mag[0][rmq_pkg::MAG_W-1] | nrm_s3.mag[1][rmq_pkg::MAG_W-1] |
		 nrm_s3.mag[2][rmq_pkg::MAG_W-1] | nrm_s3.mag[3][rmq_pkg::MAG_W-1]))
		else $error("normalized word has no magnitude in the top octave");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && q_full |=> v_s3 && $stable(nrm_s3))
		else $error("front stage lost a word while the queue was full");

endmodule

FILE: hdl/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Sum of squares, pipelined integer square root and four pipelined
// restoring dividers with rounding, ending in a two-word output buffer.
// ----------------------------------------------------------------------------
module rmq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  rmq_pkg::rmq_norm_t q_rdata,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output rmq_pkg::rmq_out_t  quat
);

	localparam int NS = rmq_pkg::SQ_STEPS;
	localparam int ND = rmq_pkg::DIV_STEPS;
	localparam int NW = rmq_pkg::N_W;
	localparam int RW = rmq_pkg::REM_W;
	localparam int QW = rmq_pkg::Q_W;

	logic adv;

	// Squares and their sum.
	logic                     v_s1, v_s2;
	logic [3:0][2*rmq_pkg::MAG_W-1:0] sq_s1;
	rmq_pkg::rmq_norm_t       c_s1, c_s2;
	logic [NW-1:0]            n_s2;

	// Square root stages; entry 0 is the sum stage.
	logic [NW-1:0]            sr_rem [0:NS];
	logic [NW-1:0]            sr_res [0:NS];
	rmq_pkg::rmq_norm_t       sr_c   [0:NS];
	logic                     sr_v   [0:NS];

	// Divider stages; entry 0 is the last square root stage.
	logic [RW-1:0]            dv_rem [1:ND][4];
	logic [QW-2:0]            dv_qt  [1:ND][4];
	logic [rmq_pkg::R_W-1:0]  dv_r   [0:ND];
	rmq_pkg::rmq_norm_t       dv_c   [0:ND];
	logic                     dv_v   [0:ND];

	// Output buffer.
	rmq_pkg::rmq_out_t ob_q [2];
	logic              ob_wp_q, ob_rp_q;
	logic [1:0]        ob_cnt_q;
	logic              ob_wr, ob_rd;
	rmq_pkg::rmq_out_t res;

	assign adv   = (ob_cnt_q != 2'd2) | pop;
	assign q_rd  = adv & ~q_empty;
	assign empty = ob_cnt_q == 2'd0;
	assign quat  = ob_q[ob_rp_q];
	assign ob_wr = adv & dv_v[ND];
	assign ob_rd = pop & ~empty;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				sq_s1[k] <= q_rdata.mag[k] * q_rdata.mag[k];
			end
			c_s1 <= q_rdata;
			n_s2 <= NW'(sq_s1[0]) + NW'(sq_s1[1]) + NW'(sq_s1[2]) + NW'(sq_s1[3]);
			c_s2 <= c_s1;
		end
	end

	assign sr_rem[0] = n_s2;
	assign sr_res[0] = '0;
	assign sr_c[0]   = c_s2;
	assign sr_v[0]   = v_s2;

	for (genvar i = 0; i < NS; i++) begin : g_sqrt
		localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2*i);
		logic [NW-1:0] trial;
		assign trial = sr_res[i] + BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (sr_rem[i] >= trial) begin
					sr_rem[i+1] <= sr_rem[i] - trial;
					sr_res[i+1] <= (sr_res[i] >> 1) + BIT;
				end else begin
					sr_rem[i+1] <= sr_rem[i];
					sr_res[i+1] <= sr_res[i] >> 1;
				end
				sr_c[i+1] <= sr_c[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[i+1] <= 1'b0;
			end else if (adv) begin
				sr_v[i+1] <= sr_v[i];
			end
		end
	end

	assign dv_r[0] = sr_res[NS][rmq_pkg::R_W-1:0];
	assign dv_c[0] = sr_c[NS];
	assign dv_v[0] = sr_v[NS];

	for (genvar j = 1; j <= ND; j++) begin : g_div
		logic [RW-1:0] rin [4];
		logic [QW-2:0] qin [4];
		always_comb begin
			for (int k = 0; k < 4; k++) begin
				if (j == 1) begin
					rin[k] = RW'(dv_c[j-1].mag[k]);
					qin[k] = '0;
				end else begin
					rin[k] = {dv_rem[j-1 > 0 ? j-1 : 1][k][RW-2:0], 1'b0};
					qin[k] = {dv_qt[j-1 > 0 ? j-1 : 1][k][QW-3:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < 4; k++) begin
					if (rin[k] >= {1'b0, dv_r[j-1]}) begin
						dv_rem[j][k] <= rin[k] - {1'b0, dv_r[j-1]};
						dv_qt[j][k]  <= qin[k] | (QW-1)'(1);
					end else begin
						dv_rem[j][k] <= rin[k];
						dv_qt[j][k]  <= qin[k];
					end
				end
				dv_r[j] <= dv_r[j-1];
				dv_c[j] <= dv_c[j-1];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j] <= 1'b0;
			end else if (adv) begin
				dv_v[j] <= dv_v[j-1];
			end
		end
	end

	function automatic logic signed [rmq_pkg::OUT_W-1:0] to_out(
		input logic neg, input logic [QW-1:0] mag);
		logic [NW-1:0] m;
		logic signed [rmq_pkg::OUT_W-1:0] v;
		m = NW'(mag);
		if (neg) begin
			v = (m > (NW'(1) << (rmq_pkg::OUT_W - 1))) ?
				{1'b1, {(rmq_pkg::OUT_W-1){1'b0}}} :
				rmq_pkg::OUT_W'(-m);
		end else begin
			v = (m > ((NW'(1) << (rmq_pkg::OUT_W - 1)) - NW'(1))) ?
				{1'b0, {(rmq_pkg::OUT_W-1){1'b1}}} :
				rmq_pkg::OUT_W'(m);
		end
		return v;
	endfunction

	always_comb begin
		logic [QW-1:0] q [4];
		for (int k = 0; k < 4; k++) begin
			// Round half up: one more quotient bit decides.
			q[k] = QW'(dv_qt[ND][k]) +
				QW'({dv_rem[ND][k][RW-2:0], 1'b0} >= {1'b0, dv_r[ND]});
		end
		if (dv_c[ND].dgn) begin
			res = '0;
			res.degenerate = 1'b1;
		end else begin
			res.quat_w = to_out(dv_c[ND].neg[0], q[0]);
			res.quat_i = to_out(dv_c[ND].neg[1], q[1]);
			res.quat_j = to_out(dv_c[ND].neg[2], q[2]);
			res.quat_k = to_out(dv_c[ND].neg[3], q[3]);
			res.degenerate = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ob_wr) begin
			ob_q[ob_wp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (adv) begin
				v_s1 <= ~q_empty;
				v_s2 <= v_s1;
			end
			if (ob_wr) begin
				ob_wp_q <= ~ob_wp_q;
			end
			if (ob_rd) begin
				ob_rp_q <= ~ob_rp_q;
			end
			if (ob_wr && !ob_rd) begin
				ob_cnt_q <= ob_cnt_q + 2'd1;
			end else if (ob_rd && !ob_wr) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
		end
	end

	a_ob_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_ob_room: assert property (@(posedge clk) disable iff (!arst_n)
		ob_wr && ob_cnt_q == 2'd2 |-> ob_rd)
		else $error("output buffer overwritten");

	a_sqrt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[0] && !dv_c[0].dgn |-> dv_r[0][rmq_pkg::R_W-1:rmq_pkg::R_W-2] != 2'b00)
		else $error("root below normalized range");

endmodule

FILE: hdl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in Q2.30 to a unit quaternion in Q2.30.
// ----------------------------------------------------------------------------
// One matrix word is taken per clock while full is low, and one quaternion
// word leaves per clock while pop is held and empty is low. A word passes
// 3 + 1 + 2 + 32 + 31 + 1 = 70 register stages: three front stages select
// and normalize, one queue slot, two stages form the squares and their
// sum, then the 32-step root pipeline and the 31-step divider pipeline
// each retire one bit per stage, and the output buffer holds the result.
// A four-word queue sits between front and back and a two-word buffer
// holds results; a stalled front never blocks the back, but a pop stall
// blocks the front once both the buffer and the queue are full.
module rotation_matrix_to_quaternion (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  rmq_pkg::rmq_in_t          matrix,
	output logic                      empty,
	input  logic                      pop,
	output rmq_pkg::rmq_out_t         quat
);

	logic               q_wr, q_full, q_rd, q_empty;
	rmq_pkg::rmq_norm_t q_wdata, q_rdata;

	rmq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.matrix (matrix),
		.full   (full),
		.q_wr   (q_wr),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	rmq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	rmq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.quat    (quat)
	);

endmodule
